>>> sv/dtp_pkg.sv
// Package for the decimal to power-of-two radix string converter.
// Holds the shared job type, status codes, register indexes and the glyph table.
// No dependencies.
package dtp_pkg;

	localparam int MAX_DIGITS = 63;
	localparam int NDIG_W = 6;
	localparam int SH_W = 9;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BASE = 2'd1;
	localparam logic [1:0] ST_INPUT = 2'd2;

	localparam logic REG_RADIX = 1'b0;
	localparam logic REG_CAP = 1'b1;

	localparam logic [2:0] RADIX_RESET = 3'd4;
	localparam logic [7:0] CAP_RESET = 8'd65;

	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef struct packed {
		logic [63:0] value;
		logic        negative;
	} job_t;

	function automatic logic [7:0] glyph(input logic [4:0] d);
		logic [7:0] g;
		if (d < 5'd10) begin
			g = 8'h30 + {3'd0, d};
		end else begin
			g = 8'h41 + {3'd0, d} - 8'd10;
		end
		return g;
	endfunction

endpackage

>>> sv/dtp_front.sv
// Front end: accepts characters, parses sign and decimal digits into a value.
// Pushes one job per string into the queue at end of string. Uses dtp_pkg.
module dtp_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    char_code,
	input  logic          char_present,
	input  logic          end_of_string,
	output logic          push_valid,
	output dtp_pkg::job_t push_job,
	input  logic          push_ready
);

	logic [63:0] acc_q, acc_n;
	logic        neg_q, neg_n;
	logic        first_q, first_n;
	logic        stopped_q, stopped_n;
	logic        accept;

	assign in_ready = push_ready;
	assign accept = in_valid && in_ready;
	assign push_valid = accept && end_of_string;
	assign push_job = '{value: acc_n, negative: neg_n};

	always_comb begin
		acc_n = acc_q;
		neg_n = neg_q;
		first_n = first_q;
		stopped_n = stopped_q;
		if (char_present) begin
			first_n = 1'b0;
			if (!stopped_q) begin
				if (first_q && char_code == dtp_pkg::CHAR_MINUS) begin
					neg_n = 1'b1;
				end else if (char_code inside {[dtp_pkg::CHAR_ZERO:dtp_pkg::CHAR_NINE]}) begin
					acc_n = (acc_q << 3) + (acc_q << 1) + {60'd0, char_code[3:0]};
				end else begin
					stopped_n = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			neg_q <= 1'b0;
			first_q <= 1'b1;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (end_of_string) begin
				acc_q <= '0;
				neg_q <= 1'b0;
				first_q <= 1'b1;
				stopped_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				neg_q <= neg_n;
				first_q <= first_n;
				stopped_q <= stopped_n;
			end
		end
	end

endmodule

>>> sv/dtp_queue.sv
// Short job queue between the parser and the emitter.
// Depth and pointer widths come from dtp_pkg.
module dtp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  dtp_pkg::job_t push_job,
	output logic          push_ready,
	output logic          pop_valid,
	output dtp_pkg::job_t pop_job,
	input  logic          pop_ready
);

	dtp_pkg::job_t                mem_q [dtp_pkg::QDEPTH];
	logic [dtp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [dtp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [dtp_pkg::QCNT_W-1:0]   count_q;
	logic                         do_push;
	logic                         do_pop;

	assign push_ready = count_q != dtp_pkg::QCNT_W'(dtp_pkg::QDEPTH);
	assign pop_valid = count_q != '0;
	assign pop_job = mem_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/dtp_back.sv
// Back end: counts the output digits of a job, checks capacity and base,
// then emits the characters one per cycle while out_ready allows, through an output register. Uses dtp_pkg.
module dtp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	input  dtp_pkg::job_t pop_job,
	output logic          pop_ready,
	input  logic [2:0]    radix_bits,
	input  logic [7:0]    capacity,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_char,
	output logic          out_char_valid,
	output logic          last_of_run,
	output logic [1:0]    status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_COUNT = 2'd1;
	localparam logic [1:0] S_SINGLE = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]                  state_q;
	logic [63:0]                 val_q;
	logic [63:0]                 t_q;
	logic                        neg_q;
	logic                        sign_pend_q;
	logic [dtp_pkg::NDIG_W-1:0]  n_q;
	logic [dtp_pkg::SH_W-1:0]    sh_q;
	logic [7:0]                  single_char_q;
	logic                        single_cv_q;
	logic [1:0]                  single_st_q;
	logic                        out_valid_q;
	logic [7:0]                  out_char_q;
	logic                        out_cv_q;
	logic                        out_last_q;
	logic [1:0]                  out_st_q;

	logic                        slot_free;
	logic                        base_ok;
	logic                        count_done;
	logic [6:0]                  total;
	logic [dtp_pkg::SH_W-1:0]    sh_first;
	logic [63:0]                 shifted;
	logic [4:0]                  mask;
	logic [4:0]                  digit;

	assign slot_free = !out_valid_q || out_ready;
	assign pop_ready = state_q == S_IDLE;
	assign base_ok = radix_bits inside {[3'd1:3'd5]};
	assign count_done = t_q == '0 || n_q == dtp_pkg::NDIG_W'(dtp_pkg::MAX_DIGITS);
	assign total = {1'b0, n_q} + {6'd0, neg_q};
	assign sh_first = ({3'd0, n_q} - 9'd1) * {6'd0, radix_bits};
	assign shifted = val_q >> sh_q[5:0];
	assign mask = 5'((6'd1 << radix_bits) - 6'd1);
	assign digit = (sh_q[dtp_pkg::SH_W-1:6] == '0) ? (shifted[4:0] & mask) : 5'd0;

	assign out_valid = out_valid_q;
	assign out_char = out_char_q;
	assign out_char_valid = out_cv_q;
	assign last_of_run = out_last_q;
	assign status = out_st_q;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && pop_valid) begin
			val_q <= pop_job.value;
			t_q <= pop_job.value;
			neg_q <= pop_job.negative;
		end else if (state_q == S_COUNT && !count_done) begin
			t_q <= t_q >> radix_bits;
		end
		if (state_q == S_COUNT && count_done) begin
			sh_q <= sh_first;
			sign_pend_q <= neg_q;
			single_char_q <= 8'd0;
			single_cv_q <= 1'b0;
			single_st_q <= dtp_pkg::ST_INPUT;
			if (!base_ok) begin
				single_st_q <= dtp_pkg::ST_BASE;
			end else if (capacity != 8'd0 && n_q == '0 && capacity >= 8'd2) begin
				single_char_q <= dtp_pkg::CHAR_ZERO;
				single_cv_q <= 1'b1;
				single_st_q <= dtp_pkg::ST_OK;
			end
		end else if (state_q == S_EMIT && slot_free) begin
			if (sign_pend_q) begin
				sign_pend_q <= 1'b0;
			end else begin
				sh_q <= sh_q - {6'd0, radix_bits};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop_valid) begin
						n_q <= '0;
						state_q <= S_COUNT;
					end
				end
				S_COUNT: begin
					if (!count_done) begin
						n_q <= n_q + 1'b1;
					end else if (!base_ok || capacity == 8'd0 || n_q == '0 ||
							{1'b0, total} >= capacity) begin
						state_q <= S_SINGLE;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_SINGLE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (slot_free && !sign_pend_q) begin
						n_q <= n_q - 1'b1;
						if (n_q == dtp_pkg::NDIG_W'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= state_q == S_SINGLE || state_q == S_EMIT;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (state_q == S_SINGLE) begin
				out_char_q <= single_char_q;
				out_cv_q <= single_cv_q;
				out_last_q <= 1'b1;
				out_st_q <= single_st_q;
			end else begin
				out_char_q <= sign_pend_q ? dtp_pkg::CHAR_MINUS : dtp_pkg::glyph(digit);
				out_cv_q <= 1'b1;
				out_last_q <= !sign_pend_q && n_q == dtp_pkg::NDIG_W'(1);
				out_st_q <= dtp_pkg::ST_OK;
			end
		end
	end

endmodule

>>> sv/decimal_to_pow2_radix_string_core.sv
// Top level of the decimal to power-of-two radix string converter.
// Instantiates dtp_front, dtp_queue and dtp_back; uses dtp_pkg.
//
// Characters of a decimal string are taken one per cycle, also while an
// earlier string is still being emitted, as long as the two-entry job queue
// has room. For each string the emitter takes the job, counts its n output
// digits (n at most 63, found by shifting the value right by radix_bits per
// cycle), and then issues its output transactions in order: the sign, if
// any, and the digits, or one error or zero transaction. Register writes are
// taken at any time with cfg_ready high and must only be issued while no
// string is in flight.
module decimal_to_pow2_radix_string_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_code,
	input  logic       char_present,
	input  logic       end_of_string,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       out_char_valid,
	output logic       last_of_run,
	output logic [1:0] status,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic [2:0]    radix_bits_q;
	logic [7:0]    capacity_q;
	logic          push_valid;
	logic          push_ready;
	dtp_pkg::job_t push_job;
	logic          pop_valid;
	logic          pop_ready;
	dtp_pkg::job_t pop_job;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_bits_q <= dtp_pkg::RADIX_RESET;
			capacity_q <= dtp_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == dtp_pkg::REG_RADIX) begin
				radix_bits_q <= cfg_data[2:0];
			end else if (cfg_index == dtp_pkg::REG_CAP) begin
				capacity_q <= cfg_data;
			end
		end
	end

	dtp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_code     (char_code),
		.char_present  (char_present),
		.end_of_string (end_of_string),
		.push_valid    (push_valid),
		.push_job      (push_job),
		.push_ready    (push_ready)
	);

	dtp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_job    (pop_job),
		.pop_ready  (pop_ready)
	);

	dtp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_job        (pop_job),
		.pop_ready      (pop_ready),
		.radix_bits     (radix_bits_q),
		.capacity       (capacity_q),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_char       (out_char),
		.out_char_valid (out_char_valid),
		.last_of_run    (last_of_run),
		.status         (status)
	);

endmodule

>>> sv/dtp_checker.sv
// Port-level checks for decimal_to_pow2_radix_string_core.
// Bound to the top level below; depends on its ports and the status codes of dtp_pkg.
module dtp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_char_valid,
	input logic       last_of_run,
	input logic [1:0] status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(status))
		else $error("Output transaction changed while stalled.");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_char_valid |-> last_of_run && status != dtp_pkg::ST_OK)
		else $error("Error transaction without last flag or error status.");

	a_char_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_char_valid |-> status == dtp_pkg::ST_OK)
		else $error("Character transaction with error status.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != dtp_pkg::ST_OK |-> out_char == 8'd0 && !out_char_valid)
		else $error("Error transaction carries a character.");

endmodule

bind decimal_to_pow2_radix_string_core dtp_checker u_dtp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.out_char       (out_char),
	.out_char_valid (out_char_valid),
	.last_of_run    (last_of_run),
	.status         (status)
);

>>> dv/decimal_to_pow2_radix_string_core_tb.sv
// Self-checking testbench for decimal_to_pow2_radix_string_core.
// Drives decimal strings and register writes, predicts every output character
// with an in-bench scoreboard; depends on dtp_pkg and the RTL only.
module decimal_to_pow2_radix_string_core_tb;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 160;
	localparam int RANDOM_ITEMS = 350;
	localparam int NUM_PHASES = 16;

	typedef struct packed {
		logic [7:0] ch;
		logic       cv;
		logic       last;
		logic [1:0] st;
	} glyph_item_t;

	typedef struct {
		logic [7:0] code;
		logic       present;
	} char_slot_t;

	class glyph_scoreboard;
		logic [2:0]  cur_radix;
		logic [7:0]  cur_capacity;
		logic [63:0] acc_value;
		logic        minus_seen;
		logic        awaiting_first;
		logic        digits_halted;
		string       glyph_set;
		glyph_item_t glyphs_due[$];
		int          errors;

		function new();
			cur_radix = dtp_pkg::RADIX_RESET;
			cur_capacity = dtp_pkg::CAP_RESET;
			acc_value = '0;
			minus_seen = 1'b0;
			awaiting_first = 1'b1;
			digits_halted = 1'b0;
			glyph_set = "0123456789ABCDEFGHIJKLMNOPQRSTUV";
			errors = 0;
		endfunction

		function void set_register(logic idx, logic [7:0] data);
			if (idx == dtp_pkg::REG_RADIX) begin
				cur_radix = data[2:0];
			end else begin
				cur_capacity = data;
			end
		endfunction

		function void push(logic [7:0] ch, logic cv, logic last, logic [1:0] st);
			glyph_item_t g;
			g.ch = ch;
			g.cv = cv;
			g.last = last;
			g.st = st;
			glyphs_due.push_back(g);
		endfunction

		function int pending();
			return glyphs_due.size();
		endfunction

		// Parses one accepted character and, on the end of a string, queues
		// the characters (or the single error transaction) it must produce.
		function void absorb_char(logic [7:0] code, logic present, logic eos);
			logic        was_first;
			logic [63:0] rest;
			logic [63:0] mask;
			int          n;
			int          total;
			int          sh;
			if (present) begin
				was_first = awaiting_first;
				awaiting_first = 1'b0;
				if (!digits_halted) begin
					if (was_first && code == dtp_pkg::CHAR_MINUS) begin
						minus_seen = 1'b1;
					end else if (code >= dtp_pkg::CHAR_ZERO && code <= dtp_pkg::CHAR_NINE) begin
						acc_value = acc_value * 64'd10 + {60'd0, code[3:0]};
					end else begin
						digits_halted = 1'b1;
					end
				end
			end
			if (!eos) return;
			if (cur_radix < 3'd1 || cur_radix > 3'd5) begin
				push(8'h00, 1'b0, 1'b1, dtp_pkg::ST_BASE);
			end else if (cur_capacity == 8'd0) begin
				push(8'h00, 1'b0, 1'b1, dtp_pkg::ST_INPUT);
			end else if (acc_value == 64'd0) begin
				if (cur_capacity < 8'd2) begin
					push(8'h00, 1'b0, 1'b1, dtp_pkg::ST_INPUT);
				end else begin
					push(dtp_pkg::CHAR_ZERO, 1'b1, 1'b1, dtp_pkg::ST_OK);
				end
			end else begin
				n = 0;
				rest = acc_value;
				while (rest != 64'd0 && n < dtp_pkg::MAX_DIGITS) begin
					n++;
					rest = rest >> cur_radix;
				end
				total = n + (minus_seen ? 1 : 0);
				if (total >= int'(cur_capacity)) begin
					push(8'h00, 1'b0, 1'b1, dtp_pkg::ST_INPUT);
				end else begin
					mask = (64'd1 << cur_radix) - 64'd1;
					if (minus_seen) push(dtp_pkg::CHAR_MINUS, 1'b1, total == 1, dtp_pkg::ST_OK);
					for (int i = n; i > 0; i--) begin
						sh = (i - 1) * int'(cur_radix);
						push(glyph_set[int'((acc_value >> sh) & mask)], 1'b1, i == 1,
							dtp_pkg::ST_OK);
					end
				end
			end
			acc_value = '0;
			minus_seen = 1'b0;
			awaiting_first = 1'b1;
			digits_halted = 1'b0;
		endfunction

		function void check_glyph(logic [7:0] ch, logic cv, logic last, logic [1:0] st);
			glyph_item_t want;
			if (glyphs_due.size() == 0) begin
				$display("%0t: unexpected transaction char=%h valid=%b last=%b status=%0d",
					$time, ch, cv, last, st);
				errors++;
				return;
			end
			want = glyphs_due.pop_front();
			if (want.ch !== ch || want.cv !== cv || want.last !== last || want.st !== st) begin
				$display("%0t: mismatch expected char=%h valid=%b last=%b status=%0d",
					$time, want.ch, want.cv, want.last, want.st);
				$display("%0t:          actual   char=%h valid=%b last=%b status=%0d",
					$time, ch, cv, last, st);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_code = 8'h00;
	logic       char_present = 1'b0;
	logic       end_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_char;
	logic       out_char_valid;
	logic       last_of_run;
	logic [1:0] status;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_index = dtp_pkg::REG_RADIX;
	logic [7:0] cfg_data = 8'h00;

	int send_gap_pct = 21;
	int recv_stall_pct = 87;
	int quiet_cycles = 0;
	int sent = 0;
	glyph_scoreboard sb;

	logic [2:0] phase_radix [NUM_PHASES] = '{3'd1, 3'd1, 3'd2, 3'd3, 3'd0, 3'd5, 3'd4,
		3'd1, 3'd6, 3'd4, 3'd5, 3'd2, 3'd7, 3'd3, 3'd1, 3'd5};
	logic [7:0] phase_cap [NUM_PHASES] = '{8'd255, 8'd20, 8'd255, 8'd10, 8'd65, 8'd3, 8'd1,
		8'd65, 8'd65, 8'd0, 8'd14, 8'd40, 8'd200, 8'd2, 8'd64, 8'd255};

	decimal_to_pow2_radix_string_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.char_present(char_present),
		.end_of_string(end_of_string),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_char(out_char),
		.out_char_valid(out_char_valid),
		.last_of_run(last_of_run),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			sb.check_glyph(out_char, out_char_valid, last_of_run, status);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("decimal_to_pow2_radix_string_core_tb: done, errors");
				$finish;
			end
		end
	end

	task automatic send_item(input logic [7:0] code, input logic present, input logic eos);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= code;
		char_present <= present;
		end_of_string <= eos;
		do @(posedge clk); while (!in_ready);
		sb.absorb_char(code, present, eos);
		sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], 1'b1, i == s.len() - 1);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_register(idx, data);
	endtask

	task automatic reconfigure(input logic [2:0] radix, input logic [7:0] cap);
		wait_drained();
		write_reg(dtp_pkg::REG_RADIX, {5'($urandom_range(31)), radix});
		write_reg(dtp_pkg::REG_CAP, cap);
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed numbers with random content; the rest are strings
	// broken by a stray character and pure noise.
	task automatic send_random_string();
		char_slot_t slots[$];
		int         kind;
		int         ndig;
		int         pick;
		kind = $urandom_range(99);
		if (kind < 70) begin
			if ($urandom_range(99) < 40) slots.push_back('{dtp_pkg::CHAR_MINUS, 1'b1});
			pick = $urandom_range(99);
			if (pick < 60) ndig = $urandom_range(1, 6);
			else if (pick < 85) ndig = $urandom_range(7, 19);
			else ndig = $urandom_range(20, 26);
			for (int i = 0; i < ndig; i++) begin
				if ($urandom_range(99) < 4) slots.push_back('{8'($urandom_range(255)), 1'b0});
				slots.push_back('{8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)), 1'b1});
			end
			if ($urandom_range(99) < 10) slots.push_back('{8'($urandom_range(255)), 1'b0});
		end else if (kind < 85) begin
			ndig = $urandom_range(1, 5);
			for (int i = 0; i < ndig; i++) begin
				slots.push_back('{8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)), 1'b1});
			end
			if ($urandom_range(1)) slots.push_back('{dtp_pkg::CHAR_MINUS, 1'b1});
			else slots.push_back('{8'($urandom_range(255)), 1'b1});
			ndig = $urandom_range(1, 5);
			for (int i = 0; i < ndig; i++) begin
				slots.push_back('{8'(dtp_pkg::CHAR_ZERO + $urandom_range(9)), 1'b1});
			end
		end else begin
			ndig = $urandom_range(1, 5);
			for (int i = 0; i < ndig; i++) begin
				slots.push_back('{8'($urandom_range(255)), 1'($urandom_range(1))});
			end
		end
		foreach (slots[i]) send_item(slots[i].code, slots[i].present, i == slots.size() - 1);
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("-");
		send_item(8'h00, 1'b0, 1'b1);
		send_text("-0");
		send_text("-255");
		send_item("9", 1'b1, 1'b0);
		send_item(8'hA5, 1'b0, 1'b0);
		send_item("x", 1'b1, 1'b0);
		send_item("5", 1'b1, 1'b1);
		send_text("1-2");
		send_item(8'hFF, 1'b1, 1'b1);
		reconfigure(3'd0, 8'd65);
		send_text("5");
		reconfigure(3'd7, 8'd65);
		send_text("5");
		reconfigure(3'd5, 8'd0);
		send_text("5");
		reconfigure(3'd5, 8'd1);
		send_item(8'h00, 1'b0, 1'b1);
		reconfigure(3'd5, 8'd2);
		send_text("-1");
		send_text("1");

		sent = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			reconfigure(phase_radix[p], phase_cap[p]);
			if (p < 6) begin
				send_gap_pct <= 21;
				recv_stall_pct <= 87;
			end else if (p < 12) begin
				send_gap_pct <= 87;
				recv_stall_pct <= 21;
			end else begin
				send_gap_pct <= 0;
				recv_stall_pct <= 0;
			end
			while (sent < RANDOM_ITEMS * (p + 1) / NUM_PHASES) send_random_string();
		end

		wait_drained();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("decimal_to_pow2_radix_string_core_tb: done, clean");
		end else begin
			$display("decimal_to_pow2_radix_string_core_tb: done, errors");
		end
		$finish;
	end

endmodule

>>> filelist.f
sv/dtp_pkg.sv
sv/dtp_front.sv
sv/dtp_queue.sv
sv/dtp_back.sv
sv/decimal_to_pow2_radix_string_core.sv
sv/dtp_checker.sv
dv/decimal_to_pow2_radix_string_core_tb.sv
